@@ rtl/core/stwp_pkg.sv @@
package stwp_pkg;

  localparam int unsigned TableDepth = 4096;
  localparam int unsigned MaxMatches = 32;

  localparam logic [63:0] LcgMul = 64'd6364136223846793005;
  localparam logic [63:0] LcgAdd = 64'd1442695040888963407;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_PROBE  = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_GATH_RD,
    ST_GATH_CMP,
    ST_MUL,
    ST_MUL_ADD,
    ST_MOD,
    ST_PICK_RD,
    ST_PICK_CMP,
    ST_OUT
  } state_e;

endpackage

@@ rtl/core/sorted_table_weighted_pick_core.sv @@
// Weighted pick from a key table held in one synchronous memory. The table
// must be loaded in ascending key order; the block does not check this.
// Clear and append are done in the idle state. A probe runs a binary search,
// gathers the matching run (up to MAX_MATCHES), runs the 64-bit multiply
// (three 32x32 partial products, each with a product and an accumulate
// step), runs a bit-serial modulo (skipped when the total weight is zero),
// walks the matches in the pick and loads the result register; the search,
// gather and pick steps are set by the single read port of the table memory.
// The result word waits in its own register, so new words are taken while it
// is held; a probe that finishes while the previous result still waits holds
// in its last state until that word has left. Probes report not found while
// enable is low. No clearing pass is needed after reset.
module sorted_table_weighted_pick_core #(
  parameter int unsigned TABLE_DEPTH = stwp_pkg::TableDepth,
  parameter int unsigned MAX_MATCHES = stwp_pkg::MaxMatches
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [63:0] entry_key_i,
  input  logic [15:0] entry_move_i,
  input  logic [15:0] entry_weight_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        found_o,
  output logic [15:0] chosen_move_o,
  output logic [5:0]  match_count_o,
  output logic [20:0] total_weight_o
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MW = $clog2(MAX_MATCHES + 1);

  logic [95:0] mem [TABLE_DEPTH];
  logic [95:0] rdata_q;
  logic [AW-1:0] raddr;
  logic we;

  stwp_pkg::state_e state_q, state_d;
  logic          enable_q;
  logic [CW-1:0] fill_q, fill_d;
  logic [63:0]   rnd_q, rnd_d;
  logic [63:0]   key_q, key_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d, idx_q, idx_d;
  logic [MW-1:0] cnt_q, cnt_d, k_q, k_d;
  logic [20:0]   tot_q, tot_d, cum_q, cum_d;
  logic [63:0]   x_q, x_d, acc_q, acc_d;
  logic [1:0]    pp_q, pp_d;
  logic [31:0]   num_q, num_d;
  logic [20:0]   rem_q, rem_d;
  logic [5:0]    bit_q, bit_d;
  logic          ovalid_q, ovalid_d, ofound_q, ofound_d;
  logic [15:0]   omove_q, omove_d;
  logic          rfound_q, rfound_d;
  logic [15:0]   rmove_q, rmove_d;
  logic [MW-1:0] rcnt_q, rcnt_d;
  logic [20:0]   rtot_q, rtot_d;
  logic [CW-1:0] mid;
  logic [63:0]   pprod;
  logic [31:0]   pa, pb;
  logic [21:0]   rsh;
  logic [20:0]   cum_n;
  logic          accept;

  assign accept = in_valid_i && !in_stall_o;
  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign we     = accept && (opcode_i == stwp_pkg::OP_APPEND) &&
                  (fill_q < CW'(TABLE_DEPTH));

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[fill_q[AW-1:0]] <= {entry_key_i, entry_move_i, entry_weight_i};
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    pa = pp_q[0] ? x_q[63:32] : x_q[31:0];
    pb = pp_q[1] ? stwp_pkg::LcgMul[63:32] : stwp_pkg::LcgMul[31:0];
  end

  always_ff @(posedge clk_i) begin
    pprod <= 64'(pa) * 64'(pb);
  end

  always_comb begin
    rsh   = {rem_q, num_q[31]};
    cum_n = cum_q + 21'(rdata_q[15:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= stwp_pkg::ST_IDLE;
      enable_q <= 1'b1;
      fill_q   <= '0;
      rnd_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      rnd_q    <= rnd_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d; lo_q <= lo_d; hi_q <= hi_d; idx_q <= idx_d;
    cnt_q <= cnt_d; k_q <= k_d; tot_q <= tot_d; cum_q <= cum_d;
    x_q <= x_d; acc_q <= acc_d; pp_q <= pp_d; num_q <= num_d;
    rem_q <= rem_d; bit_q <= bit_d; ofound_q <= ofound_d; omove_q <= omove_d;
    rfound_q <= rfound_d; rmove_q <= rmove_d; rcnt_q <= rcnt_d; rtot_q <= rtot_d;
  end

  always_comb begin
    state_d = state_q; fill_d = fill_q; rnd_d = rnd_q; key_d = key_q;
    lo_d = lo_q; hi_d = hi_q; idx_d = idx_q; cnt_d = cnt_q; k_d = k_q;
    tot_d = tot_q; cum_d = cum_q; x_d = x_q; acc_d = acc_q; pp_d = pp_q;
    num_d = num_q; rem_d = rem_q; bit_d = bit_q;
    ovalid_d = ovalid_q && out_stall_i;
    ofound_d = ofound_q; omove_d = omove_q;
    rfound_d = rfound_q; rmove_d = rmove_q; rcnt_d = rcnt_q; rtot_d = rtot_q;
    raddr = mid[AW-1:0];
    in_stall_o = 1'b1;
    unique case (state_q)
      stwp_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (accept) begin
          key_d = entry_key_i; lo_d = '0; hi_d = fill_q;
          cnt_d = '0; tot_d = '0;
          unique case (opcode_i)
            stwp_pkg::OP_CLEAR:  fill_d = '0;
            stwp_pkg::OP_APPEND: if (we) fill_d = fill_q + 1'b1;
            stwp_pkg::OP_PROBE: begin
              if (!enable_q) begin
                ofound_d = 1'b0; omove_d = '0;
                state_d = stwp_pkg::ST_OUT;
              end else begin
                state_d = stwp_pkg::ST_SRCH_RD;
              end
            end
            default: ;
          endcase
        end
      end
      stwp_pkg::ST_SRCH_RD: begin
        if (lo_q < hi_q) begin
          state_d = stwp_pkg::ST_SRCH_CMP;
        end else begin
          idx_d = lo_q;
          state_d = stwp_pkg::ST_GATH_RD;
        end
      end
      stwp_pkg::ST_SRCH_CMP: begin
        if (rdata_q[95:32] < key_q) lo_d = mid + 1'b1;
        else hi_d = mid;
        state_d = stwp_pkg::ST_SRCH_RD;
      end
      stwp_pkg::ST_GATH_RD: begin
        raddr = idx_q[AW-1:0];
        if (idx_q < fill_q && cnt_q < MW'(MAX_MATCHES)) begin
          state_d = stwp_pkg::ST_GATH_CMP;
        end else if (cnt_q == '0) begin
          ofound_d = 1'b0; omove_d = '0;
          state_d = stwp_pkg::ST_OUT;
        end else begin
          x_d = rnd_q ^ key_q; acc_d = stwp_pkg::LcgAdd; pp_d = '0;
          state_d = stwp_pkg::ST_MUL;
        end
      end
      stwp_pkg::ST_GATH_CMP: begin
        raddr = idx_q[AW-1:0];
        if (rdata_q[95:32] == key_q) begin
          cnt_d = cnt_q + 1'b1;
          tot_d = tot_q + 21'(rdata_q[15:0]);
          idx_d = idx_q + 1'b1;
          state_d = stwp_pkg::ST_GATH_RD;
        end else if (cnt_q == '0) begin
          ofound_d = 1'b0; omove_d = '0;
          state_d = stwp_pkg::ST_OUT;
        end else begin
          x_d = rnd_q ^ key_q; acc_d = stwp_pkg::LcgAdd; pp_d = '0;
          state_d = stwp_pkg::ST_MUL;
        end
      end
      stwp_pkg::ST_MUL: state_d = stwp_pkg::ST_MUL_ADD;
      stwp_pkg::ST_MUL_ADD: begin
        unique case (pp_q)
          2'd0: acc_d = acc_q + pprod;
          2'd1: acc_d = acc_q + {pprod[31:0], 32'd0};
          2'd2: acc_d = acc_q + {pprod[31:0], 32'd0};
          default: ;
        endcase
        pp_d = pp_q + 1'b1;
        if (pp_q == 2'd2) begin
          rnd_d = acc_d;
          num_d = acc_d[63:32]; rem_d = '0; bit_d = '0;
          state_d = (tot_q == '0) ? stwp_pkg::ST_PICK_RD : stwp_pkg::ST_MOD;
          idx_d = lo_q; k_d = '0; cum_d = '0;
        end else begin
          state_d = stwp_pkg::ST_MUL;
        end
      end
      stwp_pkg::ST_MOD: begin
        if (rsh >= {1'b0, tot_q}) rem_d = 21'(rsh - {1'b0, tot_q});
        else rem_d = rsh[20:0];
        num_d = {num_q[30:0], 1'b0};
        bit_d = bit_q + 1'b1;
        if (bit_q == 6'd31) state_d = stwp_pkg::ST_PICK_RD;
      end
      stwp_pkg::ST_PICK_RD: begin
        raddr = idx_q[AW-1:0];
        state_d = stwp_pkg::ST_PICK_CMP;
      end
      stwp_pkg::ST_PICK_CMP: begin
        raddr = idx_q[AW-1:0];
        cum_d = cum_n;
        if (tot_q == '0 || rem_q < cum_n || k_q == cnt_q - 1'b1) begin
          ofound_d = 1'b1; omove_d = rdata_q[31:16];
          state_d = stwp_pkg::ST_OUT;
        end else begin
          k_d = k_q + 1'b1; idx_d = idx_q + 1'b1;
          state_d = stwp_pkg::ST_PICK_RD;
        end
      end
      stwp_pkg::ST_OUT: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1;
          rfound_d = ofound_q;
          rmove_d  = omove_q;
          rcnt_d   = ofound_q ? cnt_q : '0;
          rtot_d   = ofound_q ? tot_q : '0;
          state_d = stwp_pkg::ST_IDLE;
        end
      end
      default: state_d = stwp_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o    = ovalid_q;
  assign found_o        = rfound_q;
  assign chosen_move_o  = rmove_q;
  assign match_count_o  = 6'(rcnt_q);
  assign total_weight_o = rtot_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (found_o || (match_count_o == '0 && total_weight_o == '0)))
    else $error("not found word with nonzero fields");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(TABLE_DEPTH)) else $error("fill count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (match_count_o != '0))
    else $error("found word without matches");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != stwp_pkg::ST_IDLE) |-> in_stall_o)
    else $error("input taken while busy");

endmodule
